[design/kcp_pkg.sv]
// Package for the Kyber coefficient compress/pack block.
// Widths, queue sizing and the queue entry type. No dependencies.
`default_nettype none
package kcp_pkg;

  localparam int COEFF_W  = 13;  // input coefficient width
  localparam int CODE_W   = 12;  // widest packed code (raw mode)
  localparam int WIDTH_W  = 4;   // comp_bits register width
  localparam int RAW_BITS = 12;  // comp_bits value meaning raw
  localparam int NUM_W    = 24;  // (x << d) + q/2 numerator width
  localparam int RECIP_W  = 20;  // floor(2^NUM_W / q) width for q >= 17
  localparam int MOD_W    = 12;  // modulus width
  localparam int ACC_W    = 19;  // 7 leftover bits + 12-bit code
  localparam int HELD_W   = 5;   // bit count in accumulator, 0..19
  localparam int Q_DEPTH  = 8;   // front-to-back queue depth
  localparam int Q_AW     = 3;
  localparam int Q_CW     = 4;   // queue count, 0..Q_DEPTH

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              last;
  } kcp_item_t;

endpackage : kcp_pkg
`default_nettype wire

[design/kcp_coeff_if.sv]
// Coefficient input channel: valid/ready with coeff and final_coeff.
// Widths from kcp_pkg.
`default_nettype none
interface kcp_coeff_if;
  logic                       valid;
  logic                       ready;
  logic [kcp_pkg::COEFF_W-1:0] coeff;
  logic                       final_coeff;

  modport source (output valid, output coeff, output final_coeff, input ready);
  modport sink   (input valid, input coeff, input final_coeff, output ready);
endinterface : kcp_coeff_if
`default_nettype wire

[design/kcp_byte_if.sv]
// Packed byte output channel: valid/ready with out_byte and out_last.
// No dependencies.
`default_nettype none
interface kcp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface : kcp_byte_if
`default_nettype wire

[design/kyber_coeff_compress_pack.sv]
// Kyber coefficient compressor and byte packer. Each beat on in_coeff carries
// one coefficient; it is reduced by one conditional subtraction of MODULUS and,
// for comp_bits 1..11, compressed to round(x*2^d/MODULUS) mod 2^d (comp_bits 12
// or more sends the low 12 bits raw, 0 acts as 1). Codes are packed LSB first
// and leave as one byte per out_bytes beat; a coefficient marked final_coeff
// flushes leftover bits zero padded and flags the last byte. Throughput is set
// by the packer's single byte output. Coefficients are accepted while earlier
// ones are in flight, as long as the queue has a slot for each. An accepted
// coefficient passes two front stages into an 8-entry queue, then the packer's
// accumulator and its output register. Write comp_bits only while idle.
// Depends on kcp_pkg, kcp_coeff_if, kcp_byte_if, kcp_front, kcp_queue, kcp_back.
`default_nettype none
module kyber_coeff_compress_pack #(
  parameter int MODULUS = 3329
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  kcp_coeff_if.sink                        in_coeff,
  kcp_byte_if.source                       out_bytes,
  input  wire logic                        cfg_we,
  input  wire logic [kcp_pkg::WIDTH_W-1:0] cfg_wdata
);
  import kcp_pkg::*;

  logic [WIDTH_W-1:0] comp_bits_r;
  logic [WIDTH_W-1:0] comp_width;
  logic               push, pop, q_valid;
  kcp_item_t          push_item, q_item;
  logic [Q_CW-1:0]    q_count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      comp_bits_r <= WIDTH_W'(RAW_BITS);
    end else if (cfg_we) begin
      comp_bits_r <= cfg_wdata;
    end
  end

  // Out-of-range widths clamp to 1 or raw.
  always_comb begin
    if (comp_bits_r == '0) begin
      comp_width = WIDTH_W'(1);
    end else if (comp_bits_r > WIDTH_W'(RAW_BITS)) begin
      comp_width = WIDTH_W'(RAW_BITS);
    end else begin
      comp_width = comp_bits_r;
    end
  end

  kcp_front #(.MODULUS(MODULUS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .comp_width (comp_width),
    .in_valid   (in_coeff.valid),
    .in_ready   (in_coeff.ready),
    .in_coeff   (in_coeff.coeff),
    .in_final   (in_coeff.final_coeff),
    .q_count    (q_count),
    .push       (push),
    .push_item  (push_item)
  );

  kcp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_count   (q_count)
  );

  kcp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .comp_width (comp_width),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .pop        (pop),
    .out_valid  (out_bytes.valid),
    .out_ready  (out_bytes.ready),
    .out_byte   (out_bytes.out_byte),
    .out_last   (out_bytes.out_last)
  );

endmodule : kyber_coeff_compress_pack
`default_nettype wire

[design/kcp_front.sv]
// Front end: accepts coefficients, subtracts q once if needed, compresses to d bits.
// Two register stages plus a reciprocal multiply; uses kcp_pkg.
`default_nettype none
module kcp_front #(
  parameter int MODULUS = 3329
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [kcp_pkg::WIDTH_W-1:0] comp_width,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [kcp_pkg::COEFF_W-1:0] in_coeff,
  input  wire logic                        in_final,
  input  wire logic [kcp_pkg::Q_CW-1:0]    q_count,
  output logic                             push,
  output kcp_pkg::kcp_item_t               push_item
);
  import kcp_pkg::*;

  localparam logic [COEFF_W-1:0] MOD_X = COEFF_W'(MODULUS);
  localparam logic [MOD_W-1:0]   MOD_M = MOD_W'(MODULUS);
  localparam logic [NUM_W-1:0]   HALF  = NUM_W'(MODULUS / 2);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << NUM_W) / MODULUS);

  logic                 v1_r, v2_r;
  logic [NUM_W-1:0]     n1_r, n2_r;
  logic [CODE_W-1:0]    raw1_r, raw2_r;
  logic                 last1_r, last2_r;
  logic [RECIP_W-1:0]   qe2_r;

  logic                 accept;
  logic [COEFF_W-1:0]   x_red;
  logic [NUM_W-1:0]     n_nxt;
  logic [NUM_W+RECIP_W-1:0] prod;
  logic [31:0]          back_prod;
  logic [NUM_W:0]       rem;
  logic [CODE_W-1:0]    q_fix;
  logic [CODE_W-1:0]    mask;
  logic [HELD_W-1:0]    occ;

  // Credit check: every item in flight already owns a queue slot.
  always_comb begin
    occ      = HELD_W'(q_count) + HELD_W'(v1_r) + HELD_W'(v2_r);
    in_ready = occ < HELD_W'(Q_DEPTH);
    accept   = in_valid && in_ready;
  end

  always_comb begin
    x_red = (in_coeff >= MOD_X) ? in_coeff - MOD_X : in_coeff;
    n_nxt = (NUM_W'(x_red) << comp_width) + HALF;
  end

  // Quotient estimate is q or q-1; one compare fixes it.
  always_comb begin
    prod      = (NUM_W+RECIP_W)'(n1_r) * (NUM_W+RECIP_W)'(RECIP);
    back_prod = 32'(qe2_r) * 32'(MOD_M);
    rem       = {1'b0, n2_r} - back_prod[NUM_W:0];
    q_fix     = qe2_r[CODE_W-1:0] + CODE_W'(rem >= (NUM_W+1)'(MOD_M));
    mask      = (CODE_W'(1) << comp_width) - CODE_W'(1);
  end

  always_comb begin
    push           = v2_r;
    push_item.last = last2_r;
    if (comp_width == WIDTH_W'(RAW_BITS)) begin
      push_item.code = raw2_r;
    end else begin
      push_item.code = q_fix & mask;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= accept;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    n1_r    <= n_nxt;
    raw1_r  <= x_red[CODE_W-1:0];
    last1_r <= in_final;
    n2_r    <= n1_r;
    raw2_r  <= raw1_r;
    last2_r <= last1_r;
    qe2_r   <= prod[NUM_W+RECIP_W-1:NUM_W];
  end

endmodule : kcp_front
`default_nettype wire

[design/kcp_queue.sv]
// Short FIFO of coded items between front end and packer.
// Entry type from kcp_pkg.
`default_nettype none
module kcp_queue (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  input  wire kcp_pkg::kcp_item_t    push_item,
  input  wire logic                  pop,
  output logic                       q_valid,
  output kcp_pkg::kcp_item_t         q_item,
  output logic [kcp_pkg::Q_CW-1:0]   q_count
);
  import kcp_pkg::*;

  kcp_item_t         store_r [Q_DEPTH];
  logic [Q_AW-1:0]   wr_r, wr_nxt, rd_r, rd_nxt;
  logic [Q_CW-1:0]   cnt_r, cnt_nxt;
  logic              do_pop;

  always_comb begin
    do_pop  = pop && (cnt_r != '0);
    wr_nxt  = push   ? wr_r + Q_AW'(1) : wr_r;
    rd_nxt  = do_pop ? rd_r + Q_AW'(1) : rd_r;
    cnt_nxt = cnt_r + Q_CW'(push) - Q_CW'(do_pop);
    q_valid = cnt_r != '0;
    q_item  = store_r[rd_r];
    q_count = cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_r] <= push_item;
    end
  end

endmodule : kcp_queue
`default_nettype wire

[design/kcp_back.sv]
// Back end: bit accumulator that packs codes LSB first, one byte per beat.
// Holds the output register; uses kcp_pkg.
`default_nettype none
module kcp_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [kcp_pkg::WIDTH_W-1:0] comp_width,
  input  wire logic                        q_valid,
  input  wire kcp_pkg::kcp_item_t          q_item,
  output logic                             pop,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [7:0]                       out_byte,
  output logic                             out_last
);
  import kcp_pkg::*;

  logic [ACC_W-1:0]  acc_r, acc_nxt, post_acc;
  logic [HELD_W-1:0] held_r, held_nxt, post_held;
  logic              last_r, last_nxt, post_last;
  logic              ov_r, ov_nxt;
  logic [7:0]        ob_r, ob_nxt;
  logic              ol_r, ol_nxt;
  logic              emit_ok, have_byte, emit, post_has, free;

  always_comb begin
    emit_ok   = !ov_r || out_ready;
    // A byte is due when 8 bits wait, or any bits wait on a stream end.
    have_byte = (held_r >= HELD_W'(8)) || (last_r && held_r != '0);
    emit      = have_byte && emit_ok;

    post_acc  = acc_r;
    post_held = held_r;
    post_last = last_r;
    if (emit) begin
      if (held_r > HELD_W'(8)) begin
        post_acc  = acc_r >> 8;
        post_held = held_r - HELD_W'(8);
      end else begin
        post_acc  = '0;
        post_held = '0;
        post_last = 1'b0;
      end
    end
    post_has = (post_held >= HELD_W'(8)) || (post_last && post_held != '0);
    free     = !post_has && (emit || !have_byte);
    pop      = free && q_valid;

    acc_nxt  = post_acc;
    held_nxt = post_held;
    last_nxt = post_last;
    if (pop) begin
      acc_nxt  = post_acc | (ACC_W'(q_item.code) << post_held[2:0]);
      held_nxt = post_held + HELD_W'(comp_width);
      last_nxt = q_item.last;
    end

    ov_nxt = ov_r;
    ob_nxt = ob_r;
    ol_nxt = ol_r;
    if (emit) begin
      ov_nxt = 1'b1;
      ob_nxt = acc_r[7:0];
      ol_nxt = last_r && (held_r <= HELD_W'(8));
    end else if (out_ready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      held_r <= '0;
      last_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      acc_r  <= acc_nxt;
      held_r <= held_nxt;
      last_r <= last_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ob_r <= ob_nxt;
    ol_r <= ol_nxt;
  end

  assign out_valid = ov_r;
  assign out_byte  = ob_r;
  assign out_last  = ol_r;

endmodule : kcp_back
`default_nettype wire

[design/kcp_checker.sv]
// Port-level checks for kyber_coeff_compress_pack, bound to the top level.
// Tracks final coefficients against flagged last bytes. No package use.
`default_nettype none
module kcp_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       in_final,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic       out_last
);

  logic [4:0] pend_r;
  logic       fin_in, last_out;

  assign fin_in   = in_valid && in_ready && in_final;
  assign last_out = out_valid && out_ready && out_last;

  // Streams ended at the input but not yet closed at the output.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + 5'(fin_in) - 5'(last_out);
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("stalled output beat changed");

  a_last_has_final: assert property (@(posedge clk) disable iff (!rst_n)
    last_out |-> pend_r != 5'd0)
    else $error("last byte without a pending final coefficient");

  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_reset_ready: assert property (@(posedge clk) !rst_n |=> in_ready)
    else $error("input not ready right after reset");

endmodule : kcp_checker

bind kyber_coeff_compress_pack kcp_checker u_kcp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_coeff.valid),
  .in_ready  (in_coeff.ready),
  .in_final  (in_coeff.final_coeff),
  .out_valid (out_bytes.valid),
  .out_ready (out_bytes.ready),
  .out_byte  (out_bytes.out_byte),
  .out_last  (out_bytes.out_last)
);
`default_nettype wire

[dv/kyber_coeff_compress_pack_test.sv]
// Testbench for kyber_coeff_compress_pack: directed table, then random streams per width.
// Scoreboard is a local bit-exact packer model. Uses kcp_pkg, kcp_coeff_if, kcp_byte_if.
`timescale 1ns / 100ps
module kyber_coeff_compress_pack_test;
  import kcp_pkg::*;

  localparam int KYBER_Q      = 3329;
  localparam int DRAIN_CYCLES = 12;   // front stages + queue + output register, with margin
  localparam int HOLD_CYCLES  = 80;
  localparam int N_DIRECTED   = 23;
  localparam int N_PHASES     = 11;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_beat_t;

  typedef struct packed {
    logic [WIDTH_W-1:0] width;
    logic [COEFF_W-1:0] coeff;
    logic               fin;
    logic [1:0]         n_typed;  // 0: use the packer model
    logic [7:0]         b0;
    logic [7:0]         b1;
    logic [7:0]         b2;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [WIDTH_W-1:0] cfg_wdata;

  kcp_coeff_if in_coeff_if ();
  kcp_byte_if  out_bytes_if ();

  kyber_coeff_compress_pack #(.MODULUS(KYBER_Q)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_coeff  (in_coeff_if),
    .out_bytes (out_bytes_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // packer model state
  logic [WIDTH_W-1:0] pack_width;
  logic [ACC_W-1:0]   pack_acc;
  logic [2:0]         pack_held;
  byte_beat_t         packed_out [0:2];
  byte_beat_t         expected_bytes [$];

  int   n_errors;
  bit   idle_on;
  logic hold_req;
  int   stream_left;

  stim_row_t dir_rows [N_DIRECTED];
  logic [WIDTH_W-1:0] phase_width [N_PHASES];
  int                 phase_items [N_PHASES];

  function automatic int pack_coeff(input logic [COEFF_W-1:0] coeff, input logic fin);
    int unsigned d, x, code, acc, held;
    int n;
    n = 0;
    if (pack_width == 0) d = 1;
    else if (pack_width > RAW_BITS) d = RAW_BITS;
    else d = 32'(pack_width);
    x = 32'(coeff);
    if (x >= KYBER_Q) x -= KYBER_Q;
    if (d >= RAW_BITS) code = x & 32'hfff;
    else code = (((x << d) + KYBER_Q / 2) / KYBER_Q) & ((32'd1 << d) - 1);
    acc = pack_acc & 32'h7f;
    held = 32'(pack_held);
    acc |= code << held;
    held += d;
    while (held >= 8) begin
      packed_out[n] = '{data: acc[7:0], last: 1'b0};
      n++;
      acc >>= 8;
      held -= 8;
    end
    if (fin) begin
      if (held > 0) begin
        packed_out[n] = '{data: acc[7:0] & ((8'd1 << held) - 8'd1), last: 1'b0};
        n++;
      end
      packed_out[n-1].last = 1'b1;  // d >= 1, so a final coefficient always yields a byte
      acc = 0;
      held = 0;
    end
    pack_acc  = acc[ACC_W-1:0];
    pack_held = held[2:0];
    return n;
  endfunction

  task automatic set_width(input logic [WIDTH_W-1:0] w);
    in_coeff_if.valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_we     <= 1'b0;
    pack_width = w;
  endtask

  task automatic maybe_idle();
    int n;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 18);
      in_coeff_if.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_coeff(input logic [COEFF_W-1:0] c, input logic fin,
                            input logic [1:0] n_typed, input logic [7:0] b0,
                            input logic [7:0] b1, input logic [7:0] b2);
    int n;
    logic [7:0] typed [0:2];
    in_coeff_if.valid       <= 1'b1;
    in_coeff_if.coeff       <= c;
    in_coeff_if.final_coeff <= fin;
    @(posedge clk);
    while (in_coeff_if.ready !== 1'b1) @(posedge clk);
    typed[0] = b0;
    typed[1] = b1;
    typed[2] = b2;
    n = pack_coeff(c, fin);
    if (n_typed != 0) begin
      for (int k = 0; k < n_typed; k++)
        expected_bytes.push_back('{data: typed[k], last: (k == n_typed - 1)});
    end else begin
      for (int k = 0; k < n; k++) expected_bytes.push_back(packed_out[k]);
    end
  endtask

  function automatic logic [COEFF_W-1:0] pick_coeff();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: return '0;
          1: return COEFF_W'(KYBER_Q - 1);
          2: return COEFF_W'(KYBER_Q);
          3: return COEFF_W'(2 * KYBER_Q - 1);
          default: return {COEFF_W{1'b1}};
        endcase
      end
      // beyond one subtraction
      1: return COEFF_W'($urandom_range(2 * KYBER_Q, (1 << COEFF_W) - 1));
      default: return COEFF_W'($urandom_range(0, 2 * KYBER_Q - 1));
    endcase
  endfunction

  // result side: check each beat, then pick ready for the next cycle
  initial begin
    byte_beat_t want;
    int gap_left;
    int hold_left;
    bit hold_done;
    gap_left  = 0;
    hold_left = 0;
    hold_done = 1'b0;
    out_bytes_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_bytes_if.valid === 1'b1 && out_bytes_if.ready === 1'b1) begin
        if (expected_bytes.size() == 0) begin
          n_errors++;
          $display("%0t: unexpected beat byte=%h last=%b", $time,
                   out_bytes_if.out_byte, out_bytes_if.out_last);
        end else begin
          want = expected_bytes.pop_front();
          if (out_bytes_if.out_byte !== want.data) begin
            n_errors++;
            $display("%0t: out_byte expected %h actual %h", $time, want.data,
                     out_bytes_if.out_byte);
          end
          if (out_bytes_if.out_last !== want.last) begin
            n_errors++;
            $display("%0t: out_last expected %b actual %b", $time, want.last,
                     out_bytes_if.out_last);
          end
        end
      end
      if (hold_req === 1'b1 && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (rst_n !== 1'b1) begin
        out_bytes_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_bytes_if.ready <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        out_bytes_if.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        gap_left = $urandom_range(1, 18) - 1;
        out_bytes_if.ready <= 1'b0;
      end else begin
        out_bytes_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    stim_row_t row;
    logic fin;
    n_errors    = 0;
    idle_on     = 1'b1;
    stream_left = 0;
    pack_width  = RAW_BITS;
    pack_acc    = '0;
    pack_held   = '0;
    hold_req                <= 1'b0;
    rst_n                   <= 1'b0;
    cfg_we                  <= 1'b0;
    cfg_wdata               <= '0;
    in_coeff_if.valid       <= 1'b0;
    in_coeff_if.coeff       <= '0;
    in_coeff_if.final_coeff <= 1'b0;

    dir_rows = '{
      // raw mode straight out of reset
      '{4'd12, 13'd0,    1'b1, 2'd2, 8'h00, 8'h00, 8'h00},
      '{4'd12, 13'd3328, 1'b1, 2'd2, 8'h00, 8'h0d, 8'h00},
      '{4'd12, 13'd6657, 1'b1, 2'd2, 8'h00, 8'h0d, 8'h00},
      '{4'd12, 13'd8191, 1'b1, 2'd2, 8'hfe, 8'h02, 8'h00},  // one subtraction only
      '{4'd12, 13'd3329, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
      '{4'd12, 13'd4095, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
      '{4'd12, 13'd1,    1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
      '{4'd12, 13'd2,    1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
      '{4'd12, 13'd4094, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
      // width zero acts as one bit
      '{4'd0,  13'd1665, 1'b1, 2'd1, 8'h01, 8'h00, 8'h00},
      '{4'd0,  13'd1664, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
      '{4'd0,  13'd5000, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
      // widths above twelve act as raw, then width eleven
      '{4'd15, 13'd4095, 1'b1, 2'd2, 8'hfe, 8'h02, 8'h00},
      '{4'd13, 13'd100,  1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
      '{4'd13, 13'd6000, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
      '{4'd11, 13'd3328, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
      '{4'd11, 13'd6000, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
      // rounds up to 2^8 and wraps; no leftover, flag rides the full byte
      '{4'd8,  13'd3328, 1'b1, 2'd1, 8'h00, 8'h00, 8'h00},
      '{4'd8,  13'd1664, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
      '{4'd8,  13'd7000, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
      '{4'd1,  13'd0,    1'b1, 2'd1, 8'h00, 8'h00, 8'h00},
      '{4'd4,  13'd6657, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
      '{4'd4,  13'd8191, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00}
    };
    phase_width = '{4'd12, 4'd1, 4'd0, 4'd7, 4'd12, 4'd5, 4'd15, 4'd11, 4'd13, 4'd2, 4'd8};
    phase_items = '{8, 8, 6, 8, 22, 8, 8, 8, 6, 6, 10};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    for (int i = 0; i < N_DIRECTED; i++) begin
      row = dir_rows[i];
      if (row.width != pack_width) set_width(row.width);
      else maybe_idle();
      send_coeff(row.coeff, row.fin, row.n_typed, row.b0, row.b1, row.b2);
    end

    for (int p = 0; p < N_PHASES; p++) begin
      set_width(phase_width[p]);
      // phases 2 and 10 run without idling; phase 4 pushes back-to-back against a held sink
      idle_on = !(p == 2 || p == 4 || p == N_PHASES - 1);
      if (p == 4) hold_req <= 1'b1;
      for (int i = 0; i < phase_items[p]; i++) begin
        if (stream_left == 0) stream_left = $urandom_range(1, 8);
        fin = (stream_left == 1);
        stream_left--;
        if (p == 6 && i == 4) begin
          in_coeff_if.valid <= 1'b0;
          while (expected_bytes.size() != 0) @(posedge clk);
        end else begin
          maybe_idle();
        end
        send_coeff(pick_coeff(), fin, 2'd0, 8'h00, 8'h00, 8'h00);
      end
    end
    // close any open stream so leftover bits come out
    send_coeff(pick_coeff(), 1'b1, 2'd0, 8'h00, 8'h00, 8'h00);
    in_coeff_if.valid <= 1'b0;

    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (n_errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #3ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule : kyber_coeff_compress_pack_test

[filelist.f]
design/kcp_pkg.sv
design/kcp_coeff_if.sv
design/kcp_byte_if.sv
design/kcp_front.sv
design/kcp_queue.sv
design/kcp_back.sv
design/kyber_coeff_compress_pack.sv
design/kcp_checker.sv
dv/kyber_coeff_compress_pack_test.sv
